// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the RTL. Each macro expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(name, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// Whenever the condition holds, the consequence holds in the same cycle.
`define ASSERT_IMPLIES(name, cond, conseq) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error("assertion failed");

// Whenever the condition holds, the consequence holds in the following cycle.
`define ASSERT_NEXT(name, cond, conseq) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error("assertion failed");

`endif

// ----- hdl/hsort_pkg.sv -----
// ----------------------------------------------------------------------------
// hsort_pkg
// Shared defaults for the heap sorter and its element store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hsort_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int WIDTH_DEF = 32;

endpackage

// ----- hdl/hsort_ram.sv -----
// ----------------------------------------------------------------------------
// hsort_ram
// Element store: one write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsort_ram #(
  parameter int DEPTH = hsort_pkg::DEPTH_DEF,
  parameter int WIDTH = hsort_pkg::WIDTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ----- hdl/heap_sorter_top.sv -----
// ----------------------------------------------------------------------------
// heap_sorter_top
// Collects signed values until a request marked last arrives, heap sorts them
// in place in the element store, then streams them out in ascending order.
// Requests are taken one per cycle while loading; a request that finds the
// store full is discarded and every result of that run reports it on dropped.
// After the last request the block stops taking input while it sorts: the heap
// build and every extraction step run sift-down passes, each begun by a setup
// read and exchange and then visiting each heap level with a two-port read of
// both children followed by a compare and write back. Each result is then
// read from the element store and loaded into the output register, waiting
// while an earlier result is not yet taken. Input is taken again as soon as
// the final result sits in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module heap_sorter_top #(
  parameter int DEPTH = hsort_pkg::DEPTH_DEF,
  parameter int WIDTH = hsort_pkg::WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] value,
  input  logic             last,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] sorted_value,
  output logic             end_of_run,
  output logic             dropped
);

  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int CHW = AW + 2;

  typedef enum logic [8:0] {
    S_LOAD     = 9'b000000001,
    S_BUILD_RD = 9'b000000010,
    S_BUILD_X  = 9'b000000100,
    S_SORT_RD  = 9'b000001000,
    S_SORT_X   = 9'b000010000,
    S_SIFT_RD  = 9'b000100000,
    S_SIFT_CMP = 9'b001000000,
    S_OUT_RD   = 9'b010000000,
    S_OUT_LD   = 9'b100000000
  } state_t;

  state_t           state, state_next;
  logic [CW-1:0]    count, count_next;
  logic             ovf, ovf_next;
  logic             sorting, sorting_next;
  logic [AW-1:0]    idx, idx_next;
  logic [AW-1:0]    node, node_next;
  logic [CW-1:0]    heap_size, size_next;
  logic [WIDTH-1:0] hole, hole_next;

  logic             we, re;
  logic [AW-1:0]    waddr, raddr_a, raddr_b;
  logic [WIDTH-1:0] wdata, rdata_a, rdata_b;

  logic [CHW-1:0]   left, right;
  logic             left_in, right_in;
  logic             pick_right;
  logic [WIDTH-1:0] big_val;
  logic [AW-1:0]    big_idx;
  logic             finish, ld_out, is_final, has_room;
  logic [CW-1:0]    n_new, half_m1, cnt_m1;

  hsort_ram #(
    .DEPTH(DEPTH),
    .WIDTH(WIDTH)
  ) u_ram (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .re     (re),
    .raddr_a(raddr_a),
    .raddr_b(raddr_b),
    .rdata_a(rdata_a),
    .rdata_b(rdata_b)
  );

  assign left       = CHW'({node, 1'b1});
  assign right      = left + CHW'(1);
  assign left_in    = left < CHW'(heap_size);
  assign right_in   = right < CHW'(heap_size);
  assign pick_right = right_in && ($signed(rdata_a) < $signed(rdata_b));
  assign big_val    = pick_right ? rdata_b : rdata_a;
  assign big_idx    = pick_right ? right[AW-1:0] : left[AW-1:0];

  assign has_room = count < CW'(DEPTH);
  assign n_new    = has_room ? count + CW'(1) : count;
  assign half_m1  = (n_new >> 1) - CW'(1);
  assign cnt_m1   = count - CW'(1);
  assign is_final = (CW'(idx) + CW'(1)) == count;
  assign in_ready = (state == S_LOAD);

  always_comb begin
    state_next   = state;
    count_next   = count;
    ovf_next     = ovf;
    sorting_next = sorting;
    idx_next     = idx;
    node_next    = node;
    size_next    = heap_size;
    hole_next    = hole;
    we           = 1'b0;
    waddr        = node;
    wdata        = hole;
    re           = 1'b0;
    raddr_a      = idx;
    raddr_b      = idx;
    finish       = 1'b0;
    ld_out       = 1'b0;

    unique case (state)
      S_LOAD: begin
        if (in_valid) begin
          if (has_room) begin
            we         = 1'b1;
            waddr      = count[AW-1:0];
            wdata      = value;
            count_next = count + CW'(1);
          end else begin
            ovf_next = 1'b1;
          end
          if (last) begin
            if (n_new < CW'(2)) begin
              idx_next   = '0;
              state_next = S_OUT_RD;
            end else begin
              idx_next     = half_m1[AW-1:0];
              sorting_next = 1'b0;
              state_next   = S_BUILD_RD;
            end
          end
        end
      end
      S_BUILD_RD: begin
        re         = 1'b1;
        raddr_a    = idx;
        state_next = S_BUILD_X;
      end
      S_BUILD_X: begin
        hole_next  = rdata_a;
        node_next  = idx;
        size_next  = count;
        state_next = S_SIFT_RD;
      end
      S_SORT_RD: begin
        re         = 1'b1;
        raddr_a    = '0;
        raddr_b    = idx;
        state_next = S_SORT_X;
      end
      S_SORT_X: begin
        // The root moves to the end of the heap; the old end value is sifted
        // down from the root through a hole.
        we         = 1'b1;
        waddr      = idx;
        wdata      = rdata_a;
        hole_next  = rdata_b;
        node_next  = '0;
        size_next  = CW'(idx);
        state_next = S_SIFT_RD;
      end
      S_SIFT_RD: begin
        if (left_in) begin
          re         = 1'b1;
          raddr_a    = left[AW-1:0];
          raddr_b    = right_in ? right[AW-1:0] : left[AW-1:0];
          state_next = S_SIFT_CMP;
        end else begin
          we     = 1'b1;
          waddr  = node;
          wdata  = hole;
          finish = 1'b1;
        end
      end
      S_SIFT_CMP: begin
        we    = 1'b1;
        waddr = node;
        if ($signed(hole) < $signed(big_val)) begin
          wdata      = big_val;
          node_next  = big_idx;
          state_next = S_SIFT_RD;
        end else begin
          wdata  = hole;
          finish = 1'b1;
        end
      end
      S_OUT_RD: begin
        re         = 1'b1;
        raddr_a    = idx;
        state_next = S_OUT_LD;
      end
      S_OUT_LD: begin
        if (!out_valid || out_ready) begin
          ld_out = 1'b1;
          if (is_final) begin
            count_next = '0;
            ovf_next   = 1'b0;
            state_next = S_LOAD;
          end else begin
            idx_next   = idx + AW'(1);
            state_next = S_OUT_RD;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase

    if (finish) begin
      if (!sorting) begin
        if (idx == '0) begin
          sorting_next = 1'b1;
          idx_next     = cnt_m1[AW-1:0];
          state_next   = S_SORT_RD;
        end else begin
          idx_next   = idx - AW'(1);
          state_next = S_BUILD_RD;
        end
      end else if (idx == AW'(1)) begin
        idx_next   = '0;
        state_next = S_OUT_RD;
      end else begin
        idx_next   = idx - AW'(1);
        state_next = S_SORT_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_LOAD;
      count   <= '0;
      ovf     <= 1'b0;
      sorting <= 1'b0;
      idx     <= '0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      ovf     <= ovf_next;
      sorting <= sorting_next;
      idx     <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    node      <= node_next;
    heap_size <= size_next;
    hole      <= hole_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      sorted_value <= rdata_a;
      end_of_run   <= is_final;
      dropped      <= ovf;
    end
  end

  `ASSERT_ALWAYS(a_count_bound, count <= CW'(DEPTH))
  `ASSERT_NEXT(a_busy_after_last, in_valid && in_ready && last, !in_ready)
  `ASSERT_IMPLIES(a_sift_in_heap, state == S_SIFT_RD || state == S_SIFT_CMP, CW'(node) < heap_size)

endmodule
